// File: hw/rtl/pdc_pkg.sv
// Shared constants, types and saturation helpers for the PID duty controller.
`timescale 1ns / 1ps
`default_nettype none
package pdc_pkg;

  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned DivW    = 73;
  localparam int unsigned DivsW   = 33;
  localparam int unsigned MulW    = 34;

  localparam logic [CfgIdxW-1:0] RegGainProp     = 8'd0;
  localparam logic [CfgIdxW-1:0] RegGainIntegral = 8'd1;
  localparam logic [CfgIdxW-1:0] RegGainDeriv    = 8'd2;
  localparam logic [CfgIdxW-1:0] RegIntegLimit   = 8'd3;
  localparam logic [CfgIdxW-1:0] RegDerivTau     = 8'd4;
  localparam logic [CfgIdxW-1:0] RegDutyMin      = 8'd5;
  localparam logic [CfgIdxW-1:0] RegDutyMax      = 8'd6;
  localparam logic [CfgIdxW-1:0] RegSlewRate     = 8'd7;

  localparam logic signed [47:0] Max48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] Min48 = 48'sh8000_0000_0000;

  typedef logic signed [47:0] term_t;

  // signed result from sign and magnitude, saturated to 48 bits
  function automatic term_t sat_mag(input logic neg, input logic [79:0] m);
    term_t r;
    if (m >= 80'h8000_0000_0000) begin
      r = neg ? Min48 : Max48;
    end else begin
      r = neg ? -$signed(m[47:0]) : $signed(m[47:0]);
    end
    return r;
  endfunction

  // 52-bit signed sum saturated to 48 bits
  function automatic term_t sat_wide(input logic signed [51:0] v);
    term_t r;
    if (!v[51] && (v[50:47] != 4'h0)) begin
      r = Max48;
    end else if (v[51] && (v[50:47] != 4'hF)) begin
      r = Min48;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  function automatic logic signed [51:0] sx52(input term_t v);
    return {{4{v[47]}}, v};
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/pdc_channels.sv
// Valid/ready channel interfaces: input request, result and configuration write.
`timescale 1ns / 1ps
`default_nettype none
interface pdc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] setpoint;
  logic signed [31:0] measured;
  logic        [23:0] step_time;
  modport source (output valid, output setpoint, output measured, output step_time,
                  input ready);
  modport sink   (input valid, input setpoint, input measured, input step_time,
                  output ready);
endinterface

interface pdc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] duty;
  logic        held;
  modport source (output valid, output duty, output held, input ready);
  modport sink   (input valid, input duty, input held, output ready);
endinterface

interface pdc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/pdc_mul.sv
// Shared unsigned multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none
module pdc_mul import pdc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic [MulW-1:0]     a_i,
  input  wire logic [MulW-1:0]     b_i,
  output logic      [2*MulW-1:0]   prod_o
);
  logic [2*MulW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;
endmodule
`default_nettype wire

// File: hw/rtl/pdc_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module pdc_div import pdc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DivW-1:0]   dividend_i,
  input  wire logic [DivsW-1:0]  divisor_i,
  output logic                   done_o,
  output logic      [DivW-1:0]   quot_o
);
  localparam int unsigned CntW = $clog2(DivW + 1);
  localparam logic [CntW-1:0] LastCnt = CntW'(DivW - 1);

  logic [DivsW-1:0] rem_q, rem_d;
  logic [DivW-1:0]  quo_q, quo_d;
  logic [DivsW-1:0] dvs_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [DivsW:0]   trial;
  logic             qbit;

  always_comb begin
    trial = {rem_q, quo_q[DivW-1]};
    qbit  = (trial >= {1'b0, dvs_q});
    rem_d = qbit ? DivsW'(trial - {1'b0, dvs_q}) : trial[DivsW-1:0];
    quo_d = {quo_q[DivW-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
endmodule
`default_nettype wire

// File: hw/rtl/pid_duty_controller.sv
// PID duty controller top level: registers, sequencer and datapath around shared units.
// A held request (zero step time) skips the datapath and goes straight to the output state.
// A computed request runs the proportional and integral steps; after the first step it adds
// the derivative divide in the bit-serial divider, and a nonzero tau adds the filter
// coefficient divide; a nonzero slew rate adds the slew limiting step to each.
// Throughput: one request at a time; ready is low from acceptance until the result is
// loaded. Asynchronous active-low reset clears state, registers to defaults, first step set.
`timescale 1ns / 1ps
`default_nettype none
module pid_duty_controller import pdc_pkg::*; #(
  parameter logic [15:0] DEADBAND = 16'd0
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pdc_in_if.sink      in_i,
  pdc_out_if.source   out_o,
  pdc_cfg_if.sink     cfg_i
);

  // sequencer codes
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_PMUL  = 5'd1;
  localparam logic [4:0] S_PUSE  = 5'd2;
  localparam logic [4:0] S_KMUL  = 5'd3;
  localparam logic [4:0] S_KUSE  = 5'd4;
  localparam logic [4:0] S_IMULH = 5'd5;
  localparam logic [4:0] S_IUSEH = 5'd6;
  localparam logic [4:0] S_IMULL = 5'd7;
  localparam logic [4:0] S_IUSEL = 5'd8;
  localparam logic [4:0] S_DMUL  = 5'd9;
  localparam logic [4:0] S_DUSE  = 5'd10;
  localparam logic [4:0] S_DDIV  = 5'd11;
  localparam logic [4:0] S_ADIV  = 5'd12;
  localparam logic [4:0] S_FMULH = 5'd13;
  localparam logic [4:0] S_FUSEH = 5'd14;
  localparam logic [4:0] S_FMULL = 5'd15;
  localparam logic [4:0] S_FUSEL = 5'd16;
  localparam logic [4:0] S_SUM   = 5'd17;
  localparam logic [4:0] S_SMUL  = 5'd18;
  localparam logic [4:0] S_SUSE  = 5'd19;
  localparam logic [4:0] S_OUT   = 5'd20;

  logic [4:0] state_q, state_d;

  // configuration
  logic signed [31:0] kp_q, ki_q, kd_q;
  logic        [30:0] lim_q;
  logic        [31:0] tau_q, slew_q;
  logic        [15:0] dmin_q, dmax_q;

  // loop state
  term_t              integ_q, df_q;
  logic signed [32:0] last_err_q;
  logic        [15:0] last_duty_q;
  logic               first_q;

  // per-request working registers
  logic signed [32:0] e_q;
  logic        [23:0] dt_q;
  term_t              p_q, t1_q, raw_q;
  logic        [55:0] part_q;
  logic        [31:0] alpha_q;
  logic               dsign_q;
  logic        [15:0] res_duty_q;
  logic               res_held_q;

  // result register
  logic        out_valid_q;
  logic [15:0] out_duty_q;
  logic        out_held_q;

  // shared units
  logic [MulW-1:0]   mul_a, mul_b;
  logic [2*MulW-1:0] prod;
  logic              div_start, div_done;
  logic [DivW-1:0]   div_dvd, div_quot;
  logic [DivsW-1:0]  div_dvs;

  pdc_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  pdc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // magnitudes of signed operands
  logic        [31:0] kp_mag, ki_mag, kd_mag;
  logic        [32:0] e_mag;
  logic signed [33:0] diff;
  logic        [33:0] diff_mag;
  logic        [47:0] t1_mag;
  logic signed [48:0] fd;
  logic        [47:0] fd_mag;

  assign kp_mag   = kp_q[31] ? 32'(-kp_q) : 32'(kp_q);
  assign ki_mag   = ki_q[31] ? 32'(-ki_q) : 32'(ki_q);
  assign kd_mag   = kd_q[31] ? 32'(-kd_q) : 32'(kd_q);
  assign e_mag    = e_q[32] ? 33'(-e_q) : 33'(e_q);
  assign diff     = {e_q[32], e_q} - {last_err_q[32], last_err_q};
  assign diff_mag = diff[33] ? 34'(-diff) : 34'(diff);
  assign t1_mag   = t1_q[47] ? 48'(-t1_q) : 48'(t1_q);
  assign fd       = {raw_q[47], raw_q} - {df_q[47], df_q};
  assign fd_mag   = fd[48] ? 48'(-fd) : fd[47:0];

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_PMUL: begin
        mul_a = {2'b0, kp_mag};
        mul_b = {1'b0, e_mag};
      end
      S_KMUL: begin
        mul_a = {2'b0, ki_mag};
        mul_b = {1'b0, e_mag};
      end
      S_IMULH: begin
        mul_a = {10'b0, t1_mag[47:24]};
        mul_b = {10'b0, dt_q};
      end
      S_IMULL: begin
        mul_a = {10'b0, t1_mag[23:0]};
        mul_b = {10'b0, dt_q};
      end
      S_DMUL: begin
        mul_a = {2'b0, kd_mag};
        mul_b = diff_mag;
      end
      S_FMULH: begin
        mul_a = {10'b0, fd_mag[47:24]};
        mul_b = {2'b0, alpha_q};
      end
      S_FMULL: begin
        mul_a = {10'b0, fd_mag[23:0]};
        mul_b = {2'b0, alpha_q};
      end
      S_SMUL: begin
        mul_a = {2'b0, slew_q};
        mul_b = {10'b0, dt_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // datapath results used by the sequencer
  logic [79:0]        wide_sum;
  term_t              it_term, integ_sum, integ_new, raw_new;
  // filter step is not saturated before it joins the filtered value
  logic signed [49:0] f_term;
  logic signed [47:0] lim_s;
  logic signed [51:0] u_sum;
  logic        [50:0] u_rnd;
  logic        [34:0] duty_raw;
  logic        [15:0] duty_clamp, duty_db;
  logic        [16:0] db_sum;
  logic        [55:0] maxd;
  logic        [15:0] sl_diff;
  logic        [56:0] sl_o, sl_rnd;
  logic               sl_up;

  always_comb begin
    wide_sum  = {part_q, 24'b0} + {12'b0, prod};
    it_term   = sat_mag(t1_q[47], {24'b0, wide_sum[79:24]});
    integ_sum = sat_wide(sx52(integ_q) + sx52(it_term));
    lim_s     = {17'b0, lim_q};
    integ_new = integ_sum;
    if (lim_q != 31'd0) begin
      if (integ_sum > lim_s) begin
        integ_new = lim_s;
      end else if (integ_sum < -lim_s) begin
        integ_new = -lim_s;
      end
    end
    raw_new = sat_mag(dsign_q, {7'b0, div_quot});
    f_term  = fd[48] ? -$signed({2'b0, wide_sum[79:32]}) : $signed({2'b0, wide_sum[79:32]});

    // sum, round, clamp and apply the deadband
    u_sum    = sx52(p_q) + sx52(integ_q) + sx52(df_q);
    u_rnd    = u_sum[51] ? 51'd0 : (u_sum[50:0] + 51'h8000);
    duty_raw = u_rnd[50:16];
    if (duty_raw < {19'b0, dmin_q}) begin
      duty_clamp = dmin_q;
    end else if (duty_raw > {19'b0, dmax_q}) begin
      duty_clamp = dmax_q;
    end else begin
      duty_clamp = duty_raw[15:0];
    end
    db_sum  = {1'b0, duty_clamp} + {1'b0, DEADBAND};
    duty_db = duty_clamp;
    if ((duty_clamp != 16'd0) && (DEADBAND != 16'd0)) begin
      duty_db = (db_sum > {1'b0, dmax_q}) ? dmax_q : db_sum[15:0];
    end

    // slew: step limited to slew_rate * dt around the last duty, Q16.40
    maxd    = prod[55:0];
    sl_up   = (res_duty_q >= last_duty_q);
    sl_diff = sl_up ? (res_duty_q - last_duty_q) : (last_duty_q - res_duty_q);
    sl_o    = {1'b0, res_duty_q, 40'b0};
    if ({1'b0, sl_diff, 40'b0} > {1'b0, maxd}) begin
      sl_o = sl_up ? ({1'b0, last_duty_q, 40'b0} + {1'b0, maxd})
                   : ({1'b0, last_duty_q, 40'b0} - {1'b0, maxd});
    end
    sl_rnd = sl_o + {17'b0, 1'b1, 39'b0};
  end

  // divider requests: derivative quotient, then filter coefficient
  always_comb begin
    div_start = 1'b0;
    div_dvd   = {prod[64:0], 8'b0};
    div_dvs   = {9'b0, dt_q};
    if (state_q == S_DUSE) begin
      div_start = 1'b1;
    end else if ((state_q == S_DDIV) && div_done && (tau_q != 32'd0)) begin
      div_start = 1'b1;
      div_dvd   = {17'b0, dt_q, 32'b0};
      div_dvs   = {1'b0, tau_q} + {9'b0, dt_q};
    end
  end

  logic in_fire, out_load;
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_o.ready);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = (in_i.step_time == 24'd0) ? S_OUT : S_PMUL;
      S_PMUL:  state_d = S_PUSE;
      S_PUSE:  state_d = S_KMUL;
      S_KMUL:  state_d = S_KUSE;
      S_KUSE:  state_d = S_IMULH;
      S_IMULH: state_d = S_IUSEH;
      S_IUSEH: state_d = S_IMULL;
      S_IMULL: state_d = S_IUSEL;
      S_IUSEL: state_d = first_q ? S_SUM : S_DMUL;
      S_DMUL:  state_d = S_DUSE;
      S_DUSE:  state_d = S_DDIV;
      S_DDIV:  if (div_done) state_d = (tau_q != 32'd0) ? S_ADIV : S_SUM;
      S_ADIV:  if (div_done) state_d = S_FMULH;
      S_FMULH: state_d = S_FUSEH;
      S_FUSEH: state_d = S_FMULL;
      S_FMULL: state_d = S_FUSEL;
      S_FUSEL: state_d = S_SUM;
      S_SUM:   state_d = (slew_q != 32'd0) ? S_SMUL : S_OUT;
      S_SMUL:  state_d = S_SUSE;
      S_SUSE:  state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control, configuration and loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kp_q        <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      lim_q       <= '0;
      tau_q       <= '0;
      dmin_q      <= '0;
      dmax_q      <= 16'hFFFF;
      slew_q      <= '0;
      integ_q     <= '0;
      df_q        <= '0;
      last_err_q  <= '0;
      last_duty_q <= '0;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          RegGainProp:     kp_q   <= cfg_i.data;
          RegGainIntegral: ki_q   <= cfg_i.data;
          RegGainDeriv:    kd_q   <= cfg_i.data;
          RegIntegLimit:   lim_q  <= cfg_i.data[30:0];
          RegDerivTau:     tau_q  <= cfg_i.data;
          RegDutyMin:      dmin_q <= cfg_i.data[15:0];
          RegDutyMax:      dmax_q <= cfg_i.data[15:0];
          RegSlewRate:     slew_q <= cfg_i.data;
          default: ;
        endcase
      end

      if (state_q == S_IUSEL) begin
        integ_q <= integ_new;
        if (first_q) df_q <= '0;
      end
      if ((state_q == S_DDIV) && div_done && (tau_q == 32'd0)) df_q <= raw_new;
      if (state_q == S_FUSEL) df_q <= sat_wide(sx52(df_q) + {{2{f_term[49]}}, f_term});

      if (out_load) begin
        out_valid_q <= 1'b1;
        if (!res_held_q) begin
          last_duty_q <= res_duty_q;
          last_err_q  <= e_q;
          first_q     <= 1'b0;
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      e_q        <= {in_i.setpoint[31], in_i.setpoint} - {in_i.measured[31], in_i.measured};
      dt_q       <= in_i.step_time;
      res_duty_q <= last_duty_q;
      res_held_q <= (in_i.step_time == 24'd0);
    end
    if (state_q == S_PUSE) p_q <= sat_mag(kp_q[31] ^ e_q[32], {28'b0, prod[67:16]});
    if (state_q == S_KUSE) t1_q <= sat_mag(ki_q[31] ^ e_q[32], {28'b0, prod[67:16]});
    if ((state_q == S_IUSEH) || (state_q == S_FUSEH)) part_q <= prod[55:0];
    if (state_q == S_DUSE) dsign_q <= kd_q[31] ^ diff[33];
    if ((state_q == S_DDIV) && div_done) raw_q <= raw_new;
    if ((state_q == S_ADIV) && div_done) alpha_q <= div_quot[31:0];
    if (state_q == S_SUM) res_duty_q <= duty_db;
    if (state_q == S_SUSE) res_duty_q <= sl_rnd[55:40];
    if (out_load) begin
      out_duty_q <= res_duty_q;
      out_held_q <= res_held_q;
    end
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.duty  = out_duty_q;
  assign out_o.held  = out_held_q;

endmodule
`default_nettype wire
